// ===== rtl/mlr_pkg.sv =====
// Shared types and constants of the midpoint line rasterizer.
`default_nettype none

package mlr_pkg;

    // Widest coordinate the datapath is built for; narrower tiles zero-extend.
    localparam int MAX_BITS = 6;
    // Decision variable and its increments span -2*(2^MAX_BITS-1) .. +2*(2^MAX_BITS-1).
    localparam int D_W = MAX_BITS + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified line, ready for the stepping engine.
    typedef struct packed {
        logic [MAX_BITS-1:0]  x0;
        logic [MAX_BITS-1:0]  y0;
        logic [MAX_BITS-1:0]  count;   // major-axis length = pixels after the first
        logic                 xmajor;
        logic                 sx_neg;
        logic                 sy_neg;
        logic signed [D_W-1:0] d0;
        logic signed [D_W-1:0] inc_s;
        logic signed [D_W-1:0] inc_d;
    } t_line_desc;

    // Status of the back end as seen by the queue and the top level.
    typedef struct packed {
        logic pop;
        logic busy;
    } t_bk_ctl;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_bk_state;

endpackage

`default_nettype wire

// ===== rtl/mlr_if.sv =====
// Handshake interfaces for line endpoints in and pixels out.
`default_nettype none

interface mlr_line_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mlr_pixel_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/mlr_front.sv =====
// Front end: accepts endpoints and works out octant, lengths and decision terms.
`default_nettype none

module mlr_front #(
    parameter int COORD_BITS = 6
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    mlr_line_if.sink          i_line,
    output mlr_pkg::t_line_desc o_desc,
    output logic              o_valid,
    input  wire logic         i_ready
);
    localparam int MB = mlr_pkg::MAX_BITS;
    localparam int DW = mlr_pkg::D_W;

    logic [COORD_BITS-1:0] w_sx, w_sy, w_ex, w_ey;
    logic [MB-1:0]         w_x0, w_y0, w_x1, w_y1;
    logic signed [DW-1:0]  w_dx, w_dy;
    logic [MB-1:0]         w_adx, w_ady, w_major, w_minor;
    logic                  w_xmajor;
    mlr_pkg::t_line_desc   w_desc;

    logic                  r_valid;
    mlr_pkg::t_line_desc   r_desc;

    assign w_sx = i_line.start_x;
    assign w_sy = i_line.start_y;
    assign w_ex = i_line.end_x;
    assign w_ey = i_line.end_y;

    always_comb begin
        w_x0 = MB'(w_sx);
        w_y0 = MB'(w_sy);
        w_x1 = MB'(w_ex);
        w_y1 = MB'(w_ey);
        w_dx = $signed({2'b00, w_x1}) - $signed({2'b00, w_x0});
        w_dy = $signed({2'b00, w_y1}) - $signed({2'b00, w_y0});
        w_adx = w_dx[DW-1] ? MB'(-w_dx) : MB'(w_dx);
        w_ady = w_dy[DW-1] ? MB'(-w_dy) : MB'(w_dy);
        // equal lengths favour x as the major axis
        w_xmajor = (w_ady <= w_adx);
        w_major  = w_xmajor ? w_adx : w_ady;
        w_minor  = w_xmajor ? w_ady : w_adx;

        w_desc.x0     = w_x0;
        w_desc.y0     = w_y0;
        w_desc.count  = w_major;
        w_desc.xmajor = w_xmajor;
        w_desc.sx_neg = w_dx[DW-1];
        w_desc.sy_neg = w_dy[DW-1];
        w_desc.inc_s  = $signed({1'b0, w_minor, 1'b0});
        w_desc.d0     = $signed({1'b0, w_minor, 1'b0}) - $signed({2'b00, w_major});
        w_desc.inc_d  = ($signed({2'b00, w_minor}) - $signed({2'b00, w_major})) <<< 1;
    end

    assign i_line.ready = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_desc       = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_line.ready) begin
            r_valid <= i_line.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.valid && i_line.ready) begin
            r_desc <= w_desc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mlr_queue.sv =====
// Short queue of classified lines between front and back end.
`default_nettype none

module mlr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  mlr_pkg::t_line_desc i_desc,
    output logic                o_valid,
    output mlr_pkg::t_line_desc o_desc,
    input  wire logic           i_pop
);
    localparam int DEPTH = mlr_pkg::QUEUE_DEPTH;
    localparam int PW    = mlr_pkg::QPTR_W;
    localparam int CW    = mlr_pkg::QCNT_W;

    mlr_pkg::t_line_desc r_mem [DEPTH];
    logic [PW-1:0]       r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                w_push, w_pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_desc       = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mlr_back.sv =====
// Back end: steps the midpoint decision variable and drives the pixel register.
`default_nettype none

module mlr_back #(
    parameter int COORD_BITS = 6
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  mlr_pkg::t_line_desc i_desc,
    output mlr_pkg::t_bk_ctl    o_ctl,
    mlr_pixel_if.source         o_pixel
);
    localparam int MB = mlr_pkg::MAX_BITS;
    localparam int DW = mlr_pkg::D_W;

    mlr_pkg::t_bk_state   r_state, n_state;
    logic [MB-1:0]        r_x, r_y, r_rem, n_x, n_y, n_rem;
    logic signed [DW-1:0] r_d, n_d, r_inc_s, r_inc_d;
    logic                 r_xmajor, r_sx_neg, r_sy_neg;
    logic                 r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic                 r_last;

    logic w_adv, w_emit, w_pop, w_straight, w_step_x, w_step_y;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlr_pkg::BK_IDLE: begin
                if (i_valid) begin
                    n_state = mlr_pkg::BK_RUN;
                end
            end
            mlr_pkg::BK_RUN: begin
                if (w_emit && (r_rem == '0)) begin
                    n_state = mlr_pkg::BK_IDLE;
                end
            end
            default: n_state = mlr_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_adv  = !r_out_valid || o_pixel.ready;
        w_pop  = 1'b0;
        w_emit = 1'b0;
        case (r_state)
            mlr_pkg::BK_IDLE: w_pop  = i_valid;
            mlr_pkg::BK_RUN:  w_emit = w_adv;
            default: begin
                w_pop  = 1'b0;
                w_emit = 1'b0;
            end
        endcase
        o_ctl.pop  = w_pop;
        o_ctl.busy = (r_state == mlr_pkg::BK_RUN);
    end

    // stepping datapath
    always_comb begin
        w_straight  = r_d[DW-1] || (r_d == '0);
        w_step_x    = !w_straight || r_xmajor;
        w_step_y    = !w_straight || !r_xmajor;
        n_x         = r_x;
        n_y         = r_y;
        n_d         = r_d;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        if (w_pop) begin
            n_x   = i_desc.x0;
            n_y   = i_desc.y0;
            n_d   = i_desc.d0;
            n_rem = i_desc.count;
        end else if (w_emit && (r_rem != '0)) begin
            if (w_step_x) begin
                n_x = r_sx_neg ? r_x - MB'(1) : r_x + MB'(1);
            end
            if (w_step_y) begin
                n_y = r_sy_neg ? r_y - MB'(1) : r_y + MB'(1);
            end
            n_d   = w_straight ? r_d + r_inc_s : r_d + r_inc_d;
            n_rem = r_rem - MB'(1);
        end
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_pixel.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlr_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_d   <= n_d;
        r_rem <= n_rem;
        if (w_pop) begin
            r_inc_s  <= i_desc.inc_s;
            r_inc_d  <= i_desc.inc_d;
            r_xmajor <= i_desc.xmajor;
            r_sx_neg <= i_desc.sx_neg;
            r_sy_neg <= i_desc.sy_neg;
        end
        if (w_emit) begin
            r_px   <= r_x[COORD_BITS-1:0];
            r_py   <= r_y[COORD_BITS-1:0];
            r_last <= (r_rem == '0);
        end
    end

    assign o_pixel.valid      = r_out_valid;
    assign o_pixel.pixel_x    = r_px;
    assign o_pixel.pixel_y    = r_py;
    assign o_pixel.last_pixel = r_last;

endmodule

`default_nettype wire

// ===== rtl/midpoint_line_rasterizer.sv =====
// Top level of the midpoint line rasterizer: front end, line queue, stepping back end.
`default_nettype none

// Draws straight lines on a 2^COORD_BITS square tile (64 by 64 by default).
// Each item on i_line carries two endpoints; the block returns the pixels of
// the line on o_pixel, first endpoint first, then one pixel per unit step
// along the major axis, so the second endpoint comes last and is marked with
// last_pixel. A line yields major+1 pixels, 1 to 2^COORD_BITS of them, where
// major is the larger of |dx| and |dy| (x wins a tie). Coincident endpoints
// give a single pixel with last_pixel set. The front end classifies a line
// (octant, step signs, decision terms) into a register and hands it to a
// two-entry queue, so up to three lines can be taken in while the back end
// is busy. The back end is a single stepping engine: it loads a line from
// the queue while idle, then steps along the line pixel by pixel, and takes
// no new line until it has stepped to the last pixel. Stalls on o_pixel hold
// the engine; a registered pixel stage keeps the output stable while it
// waits. No configuration, no state between lines, nothing to clear after
// reset.
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mlr_line_if.sink    i_line,
    mlr_pixel_if.source o_pixel
);

    // front to queue
    mlr_pkg::t_line_desc w_fr_desc;
    logic                w_fr_valid;
    logic                w_q_ready;

    // queue to back end
    mlr_pkg::t_line_desc w_q_desc;
    logic                w_q_valid;
    mlr_pkg::t_bk_ctl    w_bk_ctl;

    // classify the endpoints and hold one line ready for the queue
    mlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (i_line),
        .o_desc  (w_fr_desc),
        .o_valid (w_fr_valid),
        .i_ready (w_q_ready)
    );

    // decouple classification from stepping
    mlr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fr_valid),
        .o_push_ready (w_q_ready),
        .i_desc       (w_fr_desc),
        .o_valid      (w_q_valid),
        .o_desc       (w_q_desc),
        .i_pop        (w_bk_ctl.pop)
    );

    // walk the line one pixel a cycle while o_pixel is not stalled
    mlr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_desc  (w_q_desc),
        .o_ctl   (w_bk_ctl),
        .o_pixel (o_pixel)
    );

`ifndef SYNTHESIS
    // the engine takes a line only when the queue has one
    a_pop_needs_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk_ctl.pop |-> w_q_valid)
        else $error("line taken from an empty queue");

    // a line is taken only by an idle engine, which then runs
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk_ctl.pop |-> !w_bk_ctl.busy)
        else $error("line taken while the engine is busy");

    a_pop_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk_ctl.pop |=> w_bk_ctl.busy)
        else $error("engine did not start on a taken line");
`endif

endmodule

`default_nettype wire

// ===== test/tb_midpoint_line_rasterizer.sv =====
// Self-checking testbench for the midpoint line rasterizer: directed and random lines.
`default_nettype none

module tb_midpoint_line_rasterizer;

    localparam int CB          = mlr_pkg::MAX_BITS;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_WAIT  = 80;
    localparam int PRINT_CAP   = 30;

    typedef logic [CB-1:0] t_coord;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    mlr_line_if  #(.COORD_BITS(CB)) line_if  ();
    mlr_pixel_if #(.COORD_BITS(CB)) pixel_if ();

    midpoint_line_rasterizer #(
        .COORD_BITS(CB)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_if),
        .o_pixel (pixel_if)
    );

    // Pixels still owed by the block, oldest first.
    t_pixel pending_pixels[$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    // Calm sides never idle; set per phase so that stretches without gaps occur.
    bit     send_calm      = 1'b0;
    bit     sink_calm      = 1'b0;
    // A long hold-off for the pixel receiver, taken up by its own process.
    int     sink_hold_req  = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int idle_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Walk the line with the midpoint decision variable and queue every pixel.
    function automatic void trace_line(input t_coord x0, input t_coord y0,
                                       input t_coord x1, input t_coord y1);
        int     dx, dy, adx, ady, step_x, step_y;
        int     major_len, minor_len, dv, inc_flat, inc_diag, px, py, k;
        bit     x_major;
        t_pixel pix;
        dx        = int'(x1) - int'(x0);
        dy        = int'(y1) - int'(y0);
        adx       = (dx < 0) ? -dx : dx;
        ady       = (dy < 0) ? -dy : dy;
        // A zero difference steps positive; x wins a tie.
        step_x    = (dx >= 0) ? 1 : -1;
        step_y    = (dy >= 0) ? 1 : -1;
        x_major   = (ady <= adx);
        major_len = x_major ? adx : ady;
        minor_len = x_major ? ady : adx;
        dv        = 2 * minor_len - major_len;
        inc_flat  = 2 * minor_len;
        inc_diag  = 2 * (minor_len - major_len);
        px        = int'(x0);
        py        = int'(y0);
        pix.x     = t_coord'(px);
        pix.y     = t_coord'(py);
        pix.last  = (major_len == 0);
        pending_pixels.push_back(pix);
        for (k = 1; k <= major_len; k++) begin
            if (dv <= 0) begin
                dv += inc_flat;
                if (x_major)
                    px += step_x;
                else
                    py += step_y;
            end else begin
                dv += inc_diag;
                px += step_x;
                py += step_y;
            end
            pix.x    = t_coord'(px);
            pix.y    = t_coord'(py);
            pix.last = (k == major_len);
            pending_pixels.push_back(pix);
        end
    endfunction

    task automatic check_pixel(input t_coord got_x, input t_coord got_y, input logic got_last);
        t_pixel want;
        if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                      got_x, got_y, got_last));
        end else begin
            want = pending_pixels.pop_front();
            if (got_x !== want.x)
                report_mismatch($sformatf("pixel_x %0d, want %0d", got_x, want.x));
            if (got_y !== want.y)
                report_mismatch($sformatf("pixel_y %0d, want %0d", got_y, want.y));
            if (got_last !== want.last)
                report_mismatch($sformatf("last_pixel %0b, want %0b at (%0d,%0d)",
                                          got_last, want.last, want.x, want.y));
        end
    endtask

    // Sample the pixel handshake with the values held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pixel_if.valid && pixel_if.ready)
            check_pixel(pixel_if.pixel_x, pixel_if.pixel_y, pixel_if.last_pixel);
    end

    // Pixel receiver: a random stall before each item, or a long hold when asked.
    initial begin : pixel_sink
        int stall;
        pixel_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_gap(sink_calm) + sink_hold_req;
            sink_hold_req = 0;
            if (stall > 0) begin
                pixel_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pixel_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!pixel_if.valid) @(posedge i_clk);
        end
    end

    // Offer one line and hold it until taken; valid stays high into a back-to-back item.
    task automatic draw_line(input t_coord x0, input t_coord y0,
                             input t_coord x1, input t_coord y1);
        int gap;
        gap = idle_gap(send_calm);
        if (gap > 0) begin
            line_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        line_if.valid   <= 1'b1;
        line_if.start_x <= x0;
        line_if.start_y <= y0;
        line_if.end_x   <= x1;
        line_if.end_y   <= y1;
        @(posedge i_clk);
        while (!line_if.ready) @(posedge i_clk);
        trace_line(x0, y0, x1, y1);
    endtask

    task automatic test_single_pixels();
        draw_line(0, 0, 0, 0);
        draw_line(63, 63, 63, 63);
        draw_line(21, 42, 21, 42);
    endtask

    task automatic test_axis_lines();
        draw_line(0, 5, 63, 5);
        draw_line(63, 9, 0, 9);
        draw_line(7, 0, 7, 63);
        draw_line(58, 63, 58, 0);
    endtask

    // Equal spans: x must be taken as the major axis.
    task automatic test_diagonals();
        draw_line(0, 0, 63, 63);
        draw_line(63, 0, 0, 63);
        draw_line(0, 63, 63, 0);
        draw_line(63, 63, 0, 0);
    endtask

    // One shallow and one steep line in each sign quadrant.
    task automatic test_octants();
        draw_line(10, 10, 40, 20);
        draw_line(40, 20, 10, 10);
        draw_line(10, 20, 40, 10);
        draw_line(40, 10, 10, 20);
        draw_line(10, 10, 20, 40);
        draw_line(20, 40, 10, 10);
        draw_line(20, 10, 10, 40);
        draw_line(10, 40, 20, 10);
    endtask

    task automatic test_short_lines();
        draw_line(5, 5, 6, 5);
        draw_line(5, 5, 6, 7);
        draw_line(1, 62, 0, 63);
    endtask

    // Stall the receiver for a long stretch while lines keep coming, so the queue fills.
    task automatic test_backpressure();
        int i;
        send_calm     = 1'b1;
        sink_calm     = 1'b1;
        sink_hold_req = 400;
        for (i = 0; i < 8; i++)
            draw_line(t_coord'($urandom), t_coord'($urandom),
                      t_coord'($urandom), t_coord'($urandom));
        send_calm = 1'b0;
        sink_calm = 1'b0;
    endtask

    task automatic test_random_lines(input int n_lines);
        int     i, shape, len;
        t_coord ax, ay, bx, by, tmp;
        for (i = 0; i < n_lines; i++) begin
            // Change the idling pattern every few dozen lines.
            if (i % 40 == 0) begin
                send_calm = ($urandom_range(0, 3) == 0);
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            ax    = t_coord'($urandom);
            ay    = t_coord'($urandom);
            bx    = t_coord'($urandom);
            by    = t_coord'($urandom);
            shape = $urandom_range(0, 9);
            case (shape)
                0: begin
                    by = ay;
                end
                1: begin
                    bx = ax;
                end
                2: begin
                    len = $urandom_range(0, 63);
                    ax  = t_coord'($urandom_range(0, 63 - len));
                    ay  = t_coord'($urandom_range(0, 63 - len));
                    bx  = t_coord'(int'(ax) + len);
                    by  = t_coord'(int'(ay) + len);
                    if ($urandom_range(0, 1)) begin
                        tmp = ax; ax = bx; bx = tmp;
                    end
                    if ($urandom_range(0, 1)) begin
                        tmp = ay; ay = by; by = tmp;
                    end
                end
                3, 4: begin
                    // Wrap round the tile edge on purpose.
                    bx = t_coord'(int'(ax) + int'($urandom_range(0, 6)) - 3);
                    by = t_coord'(int'(ay) + int'($urandom_range(0, 6)) - 3);
                end
                default: ;
            endcase
            draw_line(ax, ay, bx, by);
        end
        send_calm = 1'b0;
        sink_calm = 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        line_if.valid   <= 1'b0;
        line_if.start_x <= '0;
        line_if.start_y <= '0;
        line_if.end_x   <= '0;
        line_if.end_y   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_pixels();
        test_axis_lines();
        test_diagonals();
        test_octants();
        test_short_lines();
        test_backpressure();
        test_random_lines(260);

        line_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== midpoint_line_rasterizer.f =====
rtl/mlr_pkg.sv
rtl/mlr_if.sv
rtl/mlr_front.sv
rtl/mlr_queue.sv
rtl/mlr_back.sv
rtl/midpoint_line_rasterizer.sv
test/tb_midpoint_line_rasterizer.sv
